>>> design/svhd_pkg.sv
// svhd_pkg: shared constants, types and helper functions of the sstv vis header detector
// no dependencies
`default_nettype none

package svhd_pkg;

  // queue and storage sizes
  localparam int CANDS      = 16;
  localparam int QW         = 4;
  localparam int CNT_W      = 5;
  localparam int SLOTS      = 10;
  localparam int SLOT_W     = 4;
  localparam int SLOT_DEPTH = CANDS * SLOTS;
  localparam int SLOT_AW    = 8;
  localparam int VOTE_DEPTH = 4096;
  localparam int VOTE_AW    = 12;
  localparam int WIN_W      = 13;
  localparam int VIS_W      = 15;
  localparam int NUM_W      = 21;
  localparam int SUM_W      = 22;
  localparam int SCNT_W     = 10;
  localparam int PADDR_W    = 6;

  // register indexes
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] REG_LEADER_HZ   = 3'd1;
  localparam logic [2:0] REG_SYNC_ENTER  = 3'd2;
  localparam logic [2:0] REG_SYNC_EXIT   = 3'd3;
  localparam logic [2:0] REG_BIT_SPLIT   = 3'd4;
  localparam logic [2:0] REG_MODES_LOW   = 3'd5;
  localparam logic [2:0] REG_MODES_HIGH  = 3'd6;

  // configuration and derived timing
  typedef struct packed {
    logic [11:0]      leader_hz;
    logic [11:0]      sync_enter_hz;
    logic [11:0]      sync_exit_hz;
    logic [11:0]      bit_split_hz;
    logic [127:0]     valid_modes;
    logic [15:0]      rate_eff;
    logic [WIN_W-1:0] win;
    logic [VIS_W-1:0] vis;
    logic [NUM_W-1:0] rate30;
  } cfg_t;

  // quotient unit status
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [4:0] quot;
  } div_stat_t;

  // slot store request
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr_en;
    logic [QW-1:0]     q;
    logic [SLOT_W-1:0] s;
    logic [QW-1:0]     clr_q;
  } slot_req_t;

  // element index of a third-of-element count 0..29
  function automatic logic [SLOT_W-1:0] third_slot(input logic [4:0] v);
    logic [SLOT_W-1:0] r;
    case (v) inside
      [5'd0:5'd2]:   r = 4'd0;
      [5'd3:5'd5]:   r = 4'd1;
      [5'd6:5'd8]:   r = 4'd2;
      [5'd9:5'd11]:  r = 4'd3;
      [5'd12:5'd14]: r = 4'd4;
      [5'd15:5'd17]: r = 4'd5;
      [5'd18:5'd20]: r = 4'd6;
      [5'd21:5'd23]: r = 4'd7;
      [5'd24:5'd26]: r = 4'd8;
      [5'd27:5'd29]: r = 4'd9;
      default:       r = 4'd15;
    endcase
    return r;
  endfunction

  function automatic logic mode_ok(input logic [127:0] modes, input logic [6:0] code);
    return modes[code];
  endfunction

endpackage

`default_nettype wire

>>> design/svhd_ifs.sv
// svhd_in_if / svhd_out_if: valid-ready channels of the header detector
// no dependencies
`default_nettype none

interface svhd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] freq_hz;
  modport source (output valid, output freq_hz, input ready);
  modport sink (input valid, input freq_hz, output ready);
endinterface

interface svhd_out_if;
  logic        valid;
  logic        ready;
  logic        lock_found;
  logic [6:0]  mode_code;
  logic        parity_ok;
  logic [31:0] header_end;
  modport source (output valid, output lock_found, output mode_code, output parity_ok,
                  output header_end, input ready);
  modport sink (input valid, input lock_found, input mode_code, input parity_ok,
                input header_end, output ready);
endinterface

`default_nettype wire

>>> design/svhd_regs.sv
// svhd_regs: apb register file and derived timing lengths
// depends on svhd_pkg
`default_nettype none

module svhd_regs import svhd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg,
  output logic               rate_wr
);

  logic [15:0]      sample_rate;
  logic [11:0]      leader_hz, sync_enter_hz, sync_exit_hz, bit_split_hz;
  logic [63:0]      modes_low, modes_high;
  logic [2:0]       idx;
  logic             wr;
  logic [15:0]      r_eff;
  logic [31:0]      prod;
  logic [12:0]      q10;
  logic [15:0]      rem_w;
  logic [3:0]       rem10;
  logic [1:0]       extra;
  logic [WIN_W-1:0] win;
  logic [VIS_W-1:0] vis;
  logic [NUM_W-1:0] rate30;

  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate   <= 16'd11025;
      leader_hz     <= 12'd1700;
      sync_enter_hz <= 12'd1250;
      sync_exit_hz  <= 12'd1350;
      bit_split_hz  <= 12'd1200;
      modes_low     <= '0;
      modes_high    <= '0;
      rate_wr       <= 1'b0;
    end else begin
      rate_wr <= 1'b0;
      if (wr) begin
        case (idx)
          REG_SAMPLE_RATE: begin
            sample_rate <= pwdata[15:0];
            rate_wr     <= 1'b1;
          end
          REG_LEADER_HZ:  leader_hz     <= pwdata[11:0];
          REG_SYNC_ENTER: sync_enter_hz <= pwdata[11:0];
          REG_SYNC_EXIT:  sync_exit_hz  <= pwdata[11:0];
          REG_BIT_SPLIT:  bit_split_hz  <= pwdata[11:0];
          REG_MODES_LOW:  modes_low     <= pwdata;
          REG_MODES_HIGH: modes_high    <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_SAMPLE_RATE: prdata = {48'd0, sample_rate};
      REG_LEADER_HZ:   prdata = {52'd0, leader_hz};
      REG_SYNC_ENTER:  prdata = {52'd0, sync_enter_hz};
      REG_SYNC_EXIT:   prdata = {52'd0, sync_exit_hz};
      REG_BIT_SPLIT:   prdata = {52'd0, bit_split_hz};
      REG_MODES_LOW:   prdata = modes_low;
      REG_MODES_HIGH:  prdata = modes_high;
      default:         prdata = '0;
    endcase
  end

  // rate / 10 by reciprocal, then window and header lengths
  always_comb begin
    r_eff  = (sample_rate == 16'd0) ? 16'd1 : sample_rate;
    prod   = 32'(r_eff) * 32'd52429;
    q10    = prod[31:19];
    rem_w  = r_eff - (16'({q10, 3'b000}) + 16'({q10, 1'b0}));
    rem10  = rem_w[3:0];
    extra  = (rem10 >= 4'd7) ? 2'd2 : ((rem10 >= 4'd4) ? 2'd1 : 2'd0);
    vis    = 15'({q10, 1'b0}) + 15'(q10) + 15'(extra);
    if (q10 == 13'd0) win = 13'd1;
    else if (q10 > 13'(VOTE_DEPTH)) win = 13'(VOTE_DEPTH);
    else win = q10;
    rate30 = 21'({r_eff, 5'b00000}) - 21'({r_eff, 1'b0});
  end

  // registered configuration view
  always_ff @(posedge clk) begin
    cfg.leader_hz     <= leader_hz;
    cfg.sync_enter_hz <= sync_enter_hz;
    cfg.sync_exit_hz  <= sync_exit_hz;
    cfg.bit_split_hz  <= bit_split_hz;
    cfg.valid_modes   <= {modes_high, modes_low};
    cfg.rate_eff      <= r_eff;
    cfg.win           <= win;
    cfg.vis           <= vis;
    cfg.rate30        <= rate30;
  end

endmodule

`default_nettype wire

>>> design/svhd_qdiv.sv
// svhd_qdiv: shared five-step restoring quotient unit, floor(num / den) below 32
// depends on svhd_pkg
`default_nettype none

module svhd_qdiv import svhd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [15:0]      den,
  output div_stat_t        stat
);

  logic [NUM_W-1:0] rem;
  logic [2:0]       step;
  logic [4:0]       quot;
  logic             busy, done;
  logic [NUM_W-1:0] dsh;

  assign dsh  = NUM_W'(den) << step;
  assign stat = '{busy: busy, done: done, quot: quot};

  // one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        quot <= 5'd0;
        step <= 3'd4;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= quot | (5'b00001 << step);
        end
        if (step == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/svhd_slot_ram.sv
// svhd_slot_ram: per-candidate element sums and counts with per-entry valid bits
// depends on svhd_pkg
`default_nettype none

module svhd_slot_ram import svhd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  slot_req_t         req,
  input  logic [SUM_W-1:0]  wr_sum,
  input  logic [SCNT_W-1:0] wr_cnt,
  output logic [SUM_W-1:0]  rd_sum,
  output logic [SCNT_W-1:0] rd_cnt
);

  logic [SUM_W+SCNT_W-1:0] mem [SLOT_DEPTH];
  logic [SLOTS-1:0]        vbits [CANDS];
  logic [SLOT_AW-1:0]      addr;
  logic [SUM_W+SCNT_W-1:0] rd_q;
  logic                    rd_v;

  assign addr = SLOT_AW'({req.q, 3'b000}) + SLOT_AW'({req.q, 1'b0}) + SLOT_AW'(req.s);

  // storage, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[addr] <= {wr_sum, wr_cnt};
    if (req.rd_en) rd_q <= mem[addr];
  end

  // valid bits, a candidate row clears when it opens
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CANDS; c++) vbits[c] <= '0;
      rd_v <= 1'b0;
    end else begin
      if (req.clr_en) vbits[req.clr_q] <= '0;
      if (req.wr_en) vbits[req.q][req.s] <= 1'b1;
      if (req.rd_en) rd_v <= vbits[req.q][req.s];
    end
  end

  assign rd_sum = rd_v ? rd_q[SUM_W+SCNT_W-1:SCNT_W] : '0;
  assign rd_cnt = rd_v ? rd_q[SCNT_W-1:0] : '0;

endmodule

`default_nettype wire

>>> design/sstv_vis_header_detector_unit.sv
// sstv_vis_header_detector_unit: top level, per-sample sequencer and leader vote store
// depends on svhd_pkg, svhd_ifs, svhd_regs, svhd_qdiv, svhd_slot_ram
// One request is one frequency sample and gives one result. A sample is worked
// through serially: each due header candidate is decoded element by element from
// the slot store, each open candidate is checked and uses the shared quotient
// unit when it is needed, with a slot store update when it falls in a summed
// window, then the vote window slides; a result may also wait for out_ch.ready. A
// lock ends the sample straight after its decode. After reset and after every write
// of sample_rate a pass over every entry clears the leader vote store, during which
// no sample is taken; register writes are taken at any time the block is idle.
`default_nettype none

module sstv_vis_header_detector_unit import svhd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  svhd_in_if.sink            in_ch,
  svhd_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DCHK = 4'd1;
  localparam logic [3:0] ST_DRD  = 4'd2;
  localparam logic [3:0] ST_DEV  = 4'd3;
  localparam logic [3:0] ST_TRIG = 4'd4;
  localparam logic [3:0] ST_ACHK = 4'd5;
  localparam logic [3:0] ST_ADIV = 4'd6;
  localparam logic [3:0] ST_ARD  = 4'd7;
  localparam logic [3:0] ST_AWR  = 4'd8;
  localparam logic [3:0] ST_VRD  = 4'd9;
  localparam logic [3:0] ST_VWR  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  cfg_t              cfg;
  logic              rate_wr;
  div_stat_t         dstat;
  logic              div_start;
  slot_req_t         sreq;
  logic [SUM_W-1:0]  rd_sum;
  logic [SCNT_W-1:0] rd_cnt;

  logic [3:0]        state;
  logic [11:0]       f_q;
  logic [31:0]       idx_q, sample_index;
  logic [QW-1:0]     head;
  logic [CNT_W-1:0]  count;
  logic              trig_on, in_sync;
  logic [31:0]       cstart [CANDS];
  logic [CNT_W-1:0]  k_q;
  logic [QW-1:0]     q_q;
  logic [SLOT_W-1:0] sj, slot_q;
  logic              start_ok, pbit;
  logic [6:0]        code;
  logic [NUM_W-1:0]  u_q;
  logic              res_lock, res_par;
  logic [6:0]        res_code;
  logic [31:0]       res_end;
  logic              out_valid, out_lock, out_par;
  logic [6:0]        out_code;
  logic [31:0]       out_end;
  logic              clr_busy;
  logic [VOTE_AW-1:0] clr_idx;
  logic [VOTE_AW-1:0] vote_position, vp_q;
  logic [WIN_W-1:0]  leader_count;
  logic              votes [VOTE_DEPTH];
  logic              vote_rd;

  logic [31:0]       age_head, age_k;
  logic [QW-1:0]     qk;
  logic [38:0]       u_full;
  logic [11:0]       limit;
  logic              below;
  logic              sub, trig_next;
  logic              opening;
  logic [QW-1:0]     q_new;
  logic [4:0]        qmid;
  logic              mid;
  logic              vote;
  logic [WIN_W-1:0]  vp_next;
  logic              vw_en, vw_data;
  logic [VOTE_AW-1:0] vw_addr;

  svhd_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .rate_wr
  );

  svhd_qdiv u_qdiv (
    .clk, .rst, .start(div_start), .num(u_q), .den(cfg.rate_eff), .stat(dstat)
  );

  svhd_slot_ram u_slots (
    .clk, .rst, .req(sreq),
    .wr_sum(SUM_W'(rd_sum + SUM_W'(f_q))), .wr_cnt(rd_cnt + SCNT_W'(1)),
    .rd_sum, .rd_cnt
  );

  // per-sample combinational helpers
  always_comb begin
    age_head = idx_q - cstart[head];
    qk       = head + k_q[QW-1:0];
    age_k    = idx_q - cstart[qk];
    u_full   = 39'(age_k) * 39'd100;
    u_q      = u_full[NUM_W-1:0];
    limit    = (sj == 4'd0 || sj == 4'd9) ? cfg.sync_enter_hz : cfg.bit_split_hz;
    below    = (rd_cnt == '0) ? (limit != 12'd0)
                              : (rd_sum < (SUM_W'(limit) * SUM_W'(rd_cnt)));
    if (f_q != 12'd0) begin
      if (!trig_on && f_q < cfg.sync_enter_hz) trig_next = 1'b1;
      else if (trig_on && f_q > cfg.sync_exit_hz) trig_next = 1'b0;
      else trig_next = trig_on;
      sub = trig_next;
    end else begin
      trig_next = trig_on;
      sub       = 1'b0;
    end
    q_new   = head + count[QW-1:0];
    opening = (state == ST_TRIG) && sub && !in_sync
            && (16'(leader_count) * 16'd5 >= 16'(cfg.win) * 16'd3)
            && (count < CNT_W'(CANDS));
    qmid    = dstat.quot - (5'(third_slot(dstat.quot)) * 5'd3);
    mid     = (qmid == 5'd1);
    vote    = (f_q >= cfg.leader_hz);
    vp_next = WIN_W'(vp_q) + WIN_W'(1);
  end

  // slot store requests
  always_comb begin
    sreq.rd_en  = (state == ST_DRD) || (state == ST_ARD);
    sreq.wr_en  = (state == ST_AWR);
    sreq.clr_en = opening;
    sreq.q      = q_q;
    sreq.s      = (state == ST_DRD) ? sj : slot_q;
    sreq.clr_q  = q_new;
  end

  assign div_start = (state == ST_ACHK) && (k_q != count) && (u_full < 39'(cfg.rate30));

  // leader vote store
  assign vw_en   = clr_busy || (state == ST_VWR);
  assign vw_addr = clr_busy ? clr_idx : vp_q;
  assign vw_data = clr_busy ? 1'b0 : vote;

  always_ff @(posedge clk) begin
    if (vw_en) votes[vw_addr] <= vw_data;
    if (state == ST_VRD) begin
      vote_rd <= votes[(WIN_W'(vote_position) >= cfg.win) ? '0 : vote_position];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sample_index  <= '0;
      head          <= '0;
      count         <= '0;
      trig_on       <= 1'b0;
      in_sync       <= 1'b0;
      out_valid     <= 1'b0;
      clr_busy      <= 1'b1;
      clr_idx       <= '0;
      leader_count  <= '0;
      vote_position <= '0;
      k_q           <= '0;
      sj            <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;

      // vote store clearing pass
      if (rate_wr) begin
        clr_busy      <= 1'b1;
        clr_idx       <= '0;
        leader_count  <= '0;
        vote_position <= '0;
      end else if (clr_busy) begin
        clr_idx <= clr_idx + VOTE_AW'(1);
        if (clr_idx == '1) clr_busy <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            f_q          <= in_ch.freq_hz;
            idx_q        <= sample_index;
            sample_index <= sample_index + 32'd1;
            res_lock     <= 1'b0;
            res_code     <= '0;
            res_par      <= 1'b0;
            res_end      <= '0;
            state        <= ST_DCHK;
          end
        end
        // pop the oldest candidate once it is due
        ST_DCHK: begin
          if (count == '0 || age_head < 32'(cfg.vis)) begin
            state <= ST_TRIG;
          end else begin
            q_q      <= head;
            head     <= head + QW'(1);
            count    <= count - CNT_W'(1);
            sj       <= '0;
            start_ok <= 1'b1;
            code     <= '0;
            state    <= ST_DRD;
          end
        end
        ST_DRD: state <= ST_DEV;
        // evaluate one element mean
        ST_DEV: begin
          if (sj == 4'd0) start_ok <= start_ok & below;
          else if (sj == 4'd8) pbit <= below;
          else if (sj != 4'd9) code[3'(sj - 4'd1)] <= below;
          if (sj == 4'd9) begin
            if (start_ok && below && mode_ok(cfg.valid_modes, code)) begin
              res_lock <= 1'b1;
              res_code <= code;
              res_par  <= (^code) == pbit;
              res_end  <= cstart[q_q] + 32'(cfg.vis);
              state    <= ST_OUT;
            end else begin
              state <= ST_DCHK;
            end
          end else begin
            sj    <= sj + 4'd1;
            state <= ST_DRD;
          end
        end
        // sync trigger and candidate opening
        ST_TRIG: begin
          trig_on <= trig_next;
          if (sub && !in_sync) in_sync <= 1'b1;
          else if (!sub && in_sync) in_sync <= 1'b0;
          if (opening) begin
            cstart[q_new] <= idx_q;
            count         <= count + CNT_W'(1);
          end
          k_q   <= '0;
          state <= ST_ACHK;
        end
        // element position of each open candidate
        ST_ACHK: begin
          if (k_q == count) begin
            state <= ST_VRD;
          end else if (div_start) begin
            q_q   <= qk;
            state <= ST_ADIV;
          end else begin
            k_q <= k_q + CNT_W'(1);
          end
        end
        ST_ADIV: begin
          if (dstat.done) begin
            if (mid) begin
              slot_q <= third_slot(dstat.quot);
              state  <= ST_ARD;
            end else begin
              k_q   <= k_q + CNT_W'(1);
              state <= ST_ACHK;
            end
          end
        end
        ST_ARD: state <= ST_AWR;
        ST_AWR: begin
          k_q   <= k_q + CNT_W'(1);
          state <= ST_ACHK;
        end
        // slide the leader window
        ST_VRD: begin
          vp_q  <= (WIN_W'(vote_position) >= cfg.win) ? '0 : vote_position;
          state <= ST_VWR;
        end
        ST_VWR: begin
          leader_count  <= leader_count - WIN_W'(vote_rd) + WIN_W'(vote);
          vote_position <= (vp_next >= cfg.win) ? '0 : vp_next[VOTE_AW-1:0];
          state         <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_lock  <= res_lock;
            out_code  <= res_code;
            out_par   <= res_par;
            out_end   <= res_end;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // handshake and result drive, no request while a clearing pass is pending
  assign in_ch.ready       = (state == ST_IDLE) && !clr_busy && !rate_wr;
  assign out_ch.valid      = out_valid;
  assign out_ch.lock_found = out_lock;
  assign out_ch.mode_code  = out_code;
  assign out_ch.parity_ok  = out_par;
  assign out_ch.header_end = out_end;

  // checks
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> !clr_busy)
    else $error("sample taken during vote clearing pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CANDS))
    else $error("candidate queue overfilled");

  a_lock_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_lock |-> mode_ok(cfg.valid_modes, out_code))
    else $error("lock reported for a mode outside the mask");

  a_div_in_adiv: assert property (@(posedge clk) disable iff (rst)
    dstat.busy |-> state == ST_ADIV)
    else $error("quotient unit running outside its state");

endmodule

`default_nettype wire
